// ===== hw/rtl/largest_gap_middle_seat_allocator_macros.svh =====
// Assertion macros for the largest-gap middle-seat allocator checker.
// Every macro samples on clock and is disabled during reset.
`ifndef LARGEST_GAP_MIDDLE_SEAT_ALLOCATOR_MACROS_SVH
`define LARGEST_GAP_MIDDLE_SEAT_ALLOCATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LGMS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LGMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lgms_pkg.sv =====
// Shared types, constants and the run ordering for the seat allocator.
// Used by the heap engine, the top level and the checker.
`timescale 1ns / 1ps

package lgms_pkg;

   localparam int SEAT_W       = 13;
   localparam int STATUS_W     = 2;
   localparam int MAX_SEATS    = 4096;
   localparam int HEAP_ENTRIES = 2048;

   localparam logic [SEAT_W-1:0] TOTAL_RESET = SEAT_W'(4096);

   localparam logic MODE_PRESEAT  = 1'b0;
   localparam logic MODE_ALLOCATE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SEAT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PRESEAT = 2'd2;

   typedef struct packed {
      logic [SEAT_W-1:0] len;
      logic [SEAT_W-1:0] start;
   } run_type;

   // one-cycle strobes from the sequencer to the heap engine
   typedef struct packed {
      logic    push;
      logic    pop;
      run_type run;
   } eng_cmd_type;

   typedef struct packed {
      logic done;
      logic empty;
   } eng_stat_type;

   // true when run x must sit above run y: longer first, then smaller start
   function automatic logic run_before(run_type x, run_type y);
      if (x.len != y.len) begin
         return x.len > y.len;
      end
      return x.start < y.start;
   endfunction

endpackage

// ===== hw/rtl/lgms_heap_ram.sv =====
// Heap storage: one write port and two registered read ports.
// Entry type from lgms_pkg.
`timescale 1ns / 1ps

module lgms_heap_ram #(
   parameter int  DEPTH = lgms_pkg::HEAP_ENTRIES,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  lgms_pkg::run_type wdata,
   input  logic             re,
   input  logic [AW-1:0]    ra_addr,
   input  logic [AW-1:0]    rb_addr,
   output lgms_pkg::run_type ra_data,
   output lgms_pkg::run_type rb_data
);

   lgms_pkg::run_type mem [DEPTH];
   lgms_pkg::run_type ra_data_ff;
   lgms_pkg::run_type rb_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         ra_data_ff <= mem[ra_addr];
         rb_data_ff <= mem[rb_addr];
      end
   end

   assign ra_data = ra_data_ff;
   assign rb_data = rb_data_ff;

endmodule

// ===== hw/rtl/lgms_heap_engine.sv =====
// Max-heap engine: push with sift-up, pop with sift-down, over lgms_heap_ram.
// Types and ordering from lgms_pkg. The moving run is held in a register.
`timescale 1ns / 1ps

module lgms_heap_engine #(
   parameter int HEAP_ENTRIES = lgms_pkg::HEAP_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lgms_pkg::eng_cmd_type cmd,
   output lgms_pkg::eng_stat_type stat,
   output lgms_pkg::run_type     popped
);

   localparam int AW = (HEAP_ENTRIES > 1) ? $clog2(HEAP_ENTRIES) : 1;
   localparam int CW = $clog2(HEAP_ENTRIES + 1);
   localparam int XW = AW + 2;

   typedef enum logic [2:0] {
      E_IDLE,
      E_UP,
      E_POP,
      E_DN,
      E_PLACE
   } eng_state_type;

   eng_state_type     state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     hole_ff, hole_in;
   lgms_pkg::run_type x_ff, x_in;
   lgms_pkg::run_type top_ff, top_in;
   logic              done_ff, done_in;

   logic              we;
   logic [AW-1:0]     waddr;
   lgms_pkg::run_type wdata;
   logic              re;
   logic [AW-1:0]     ra_addr;
   logic [AW-1:0]     rb_addr;
   lgms_pkg::run_type ra_data;
   lgms_pkg::run_type rb_data;

   logic [AW-1:0]     par_hole;
   logic [AW-1:0]     par_par;
   logic [XW-1:0]     l_x;
   logic [XW-1:0]     r_x;
   logic [XW-1:0]     cnt_x;
   logic              use_r;
   lgms_pkg::run_type child;
   logic [AW-1:0]     child_idx;
   logic [XW-1:0]     nl_x;
   logic [XW-1:0]     nr_x;

   function automatic logic [AW-1:0] parent_of(logic [AW-1:0] idx);
      return (idx - AW'(1)) >> 1;
   endfunction

   lgms_heap_ram #(
      .DEPTH (HEAP_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .re      (re),
      .ra_addr (ra_addr),
      .rb_addr (rb_addr),
      .ra_data (ra_data),
      .rb_data (rb_data)
   );

   assign par_hole  = parent_of(hole_ff);
   assign par_par   = parent_of(par_hole);
   assign l_x       = XW'({hole_ff, 1'b1});
   assign r_x       = l_x + XW'(1);
   assign cnt_x     = XW'(count_ff);
   assign use_r     = (r_x < cnt_x) && lgms_pkg::run_before(rb_data, ra_data);
   assign child     = use_r ? rb_data : ra_data;
   assign child_idx = use_r ? AW'(r_x) : AW'(l_x);
   assign nl_x      = XW'({child_idx, 1'b1});
   assign nr_x      = nl_x + XW'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      hole_in  = hole_ff;
      x_in     = x_ff;
      top_in   = top_ff;
      done_in  = 1'b0;
      we       = 1'b0;
      waddr    = hole_ff;
      wdata    = x_ff;
      re       = 1'b0;
      ra_addr  = '0;
      rb_addr  = '0;
      case (state_ff)
         E_IDLE: begin
            if (cmd.push) begin
               if (count_ff >= CW'(HEAP_ENTRIES)) begin
                  // drop the push into a full heap
                  done_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
                  x_in     = cmd.run;
                  hole_in  = AW'(count_ff);
                  if (count_ff == '0) begin
                     we      = 1'b1;
                     waddr   = '0;
                     wdata   = cmd.run;
                     done_in = 1'b1;
                  end else begin
                     re       = 1'b1;
                     ra_addr  = parent_of(AW'(count_ff));
                     state_in = E_UP;
                  end
               end
            end else if (cmd.pop) begin
               re       = 1'b1;
               ra_addr  = '0;
               rb_addr  = AW'(count_ff - CW'(1));
               count_in = count_ff - CW'(1);
               state_in = E_POP;
            end
         end
         E_UP: begin
            we    = 1'b1;
            waddr = hole_ff;
            if (lgms_pkg::run_before(x_ff, ra_data)) begin
               // move the parent down into the hole and climb
               wdata   = ra_data;
               hole_in = par_hole;
               if (par_hole == '0) begin
                  state_in = E_PLACE;
               end else begin
                  re      = 1'b1;
                  ra_addr = par_par;
               end
            end else begin
               wdata    = x_ff;
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         E_POP: begin
            top_in  = ra_data;
            x_in    = rb_data;
            hole_in = '0;
            if (count_ff == '0) begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else if (count_ff == CW'(1)) begin
               we       = 1'b1;
               waddr    = '0;
               wdata    = rb_data;
               done_in  = 1'b1;
               state_in = E_IDLE;
            end else begin
               re       = 1'b1;
               ra_addr  = AW'(1);
               rb_addr  = (count_ff > CW'(2)) ? AW'(2) : AW'(1);
               state_in = E_DN;
            end
         end
         E_DN: begin
            we    = 1'b1;
            waddr = hole_ff;
            if (lgms_pkg::run_before(child, x_ff)) begin
               // move the better child up into the hole and descend
               wdata   = child;
               hole_in = child_idx;
               if (nl_x >= cnt_x) begin
                  state_in = E_PLACE;
               end else begin
                  re      = 1'b1;
                  ra_addr = AW'(nl_x);
                  rb_addr = (nr_x < cnt_x) ? AW'(nr_x) : AW'(nl_x);
               end
            end else begin
               wdata    = x_ff;
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         E_PLACE: begin
            we       = 1'b1;
            waddr    = hole_ff;
            wdata    = x_ff;
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      x_ff    <= x_in;
      top_ff  <= top_in;
      if (reset) begin
         state_ff <= E_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   assign stat.done  = done_ff;
   assign stat.empty = (count_ff == '0);
   assign popped     = top_ff;

endmodule

// ===== hw/rtl/largest_gap_middle_seat_allocator.sv =====
// Largest-gap middle-seat allocator: sequencer, output register and heap engine.
// Depends on lgms_pkg and lgms_heap_engine.
`timescale 1ns / 1ps
// One item at a time: a new item is taken in the cycle the previous result turns valid.
// A preseat pushes at most one run into the heap before its result. An allocate on an empty
// heap returns no seat; otherwise it pops the best run and pushes up to two remainders, and
// the first allocate also pushes the tail run first. Each heap step walks one level per cycle
// through the memory, over a heap of 11 levels by default.
// Synchronous active-high reset empties the heap at once (count to zero), total_seats 4096.

module largest_gap_middle_seat_allocator #(
   parameter int HEAP_ENTRIES = lgms_pkg::HEAP_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [lgms_pkg::SEAT_W-1:0]   req_seat,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lgms_pkg::STATUS_W-1:0] rsp_status,
   output logic [lgms_pkg::SEAT_W-1:0]   rsp_assigned_seat,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lgms_pkg::SEAT_W-1:0]   csr_total_seats
);

   localparam int SW = lgms_pkg::SEAT_W;
   localparam int NW = SW + 1;

   typedef enum logic [3:0] {
      T_IDLE,
      T_DECODE,
      T_PRE_WAIT,
      T_TAIL_WAIT,
      T_CHECK,
      T_POP_WAIT,
      T_LEFT_WAIT,
      T_RIGHT_WAIT,
      T_OUT
   } top_state_type;

   top_state_type                 state_ff, state_in;
   logic                          mode_ff, mode_in;
   logic [SW-1:0]                 seat_ff, seat_in;
   logic [lgms_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [SW-1:0]                 given_ff, given_in;
   logic [NW-1:0]                 next_ff, next_in;
   logic                          tail_ff, tail_in;
   logic [SW-1:0]                 total_ff, total_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lgms_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SW-1:0]                 rsp_seat_ff, rsp_seat_in;

   lgms_pkg::eng_cmd_type         cmd;
   lgms_pkg::eng_stat_type        stat;
   lgms_pkg::run_type             popped;

   logic [SW-1:0]                 total;
   logic                          pre_bad;
   logic [NW-1:0]                 tail_end;
   logic [NW-1:0]                 run_end;
   logic [NW:0]                   mid_sum;
   logic [SW-1:0]                 mid;
   logic                          left_ne;
   logic                          right_ne;
   lgms_pkg::run_type             pre_run;
   lgms_pkg::run_type             tail_run;
   lgms_pkg::run_type             left_run;
   lgms_pkg::run_type             right_run;

   lgms_heap_engine #(
      .HEAP_ENTRIES (HEAP_ENTRIES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .popped (popped)
   );

   assign total = (32'(total_ff) > lgms_pkg::MAX_SEATS) ? SW'(lgms_pkg::MAX_SEATS) : total_ff;

   assign pre_bad = tail_ff || (seat_ff == '0) || (seat_ff > total)
                    || ({1'b0, seat_ff} < next_ff);
   assign pre_run.len   = SW'({1'b0, seat_ff} - next_ff);
   assign pre_run.start = SW'(next_ff);

   assign tail_end       = {1'b0, total} + NW'(1);
   assign tail_run.len   = SW'(tail_end - next_ff);
   assign tail_run.start = SW'(next_ff);

   // middle seat of the popped run and its two remainders
   assign run_end         = {1'b0, popped.start} + {1'b0, popped.len} - NW'(1);
   assign mid_sum         = {2'b0, popped.start} + {1'b0, run_end};
   assign mid             = mid_sum[SW:1];
   assign left_ne         = mid > popped.start;
   assign right_ne        = run_end > {1'b0, mid};
   assign left_run.len    = mid - popped.start;
   assign left_run.start  = popped.start;
   assign right_run.len   = SW'(run_end - {1'b0, mid});
   assign right_run.start = mid + SW'(1);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      seat_in       = seat_ff;
      status_in     = status_ff;
      given_in      = given_ff;
      next_in       = next_ff;
      tail_in       = tail_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_seat_in   = rsp_seat_ff;
      cmd.push      = 1'b0;
      cmd.pop       = 1'b0;
      cmd.run       = tail_run;

      if (csr_valid) begin
         total_in = csr_total_seats;
      end

      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               seat_in  = req_seat;
               state_in = T_DECODE;
            end
         end
         T_DECODE: begin
            status_in = lgms_pkg::STATUS_OK;
            given_in  = '0;
            if (mode_ff == lgms_pkg::MODE_PRESEAT) begin
               if (pre_bad) begin
                  status_in = lgms_pkg::STATUS_BAD_PRESEAT;
                  state_in  = T_OUT;
               end else begin
                  next_in = {1'b0, seat_ff} + NW'(1);
                  if ({1'b0, seat_ff} > next_ff) begin
                     cmd.push = 1'b1;
                     cmd.run  = pre_run;
                     state_in = T_PRE_WAIT;
                  end else begin
                     state_in = T_OUT;
                  end
               end
            end else if (!tail_ff) begin
               tail_in = 1'b1;
               if (tail_end > next_ff) begin
                  cmd.push = 1'b1;
                  cmd.run  = tail_run;
                  state_in = T_TAIL_WAIT;
               end else begin
                  state_in = T_CHECK;
               end
            end else begin
               state_in = T_CHECK;
            end
         end
         T_PRE_WAIT: begin
            if (stat.done) begin
               state_in = T_OUT;
            end
         end
         T_TAIL_WAIT: begin
            if (stat.done) begin
               state_in = T_CHECK;
            end
         end
         T_CHECK: begin
            if (stat.empty) begin
               status_in = lgms_pkg::STATUS_NO_SEAT;
               state_in  = T_OUT;
            end else begin
               cmd.pop  = 1'b1;
               state_in = T_POP_WAIT;
            end
         end
         T_POP_WAIT: begin
            if (stat.done) begin
               given_in = mid;
               if (left_ne) begin
                  cmd.push = 1'b1;
                  cmd.run  = left_run;
                  state_in = T_LEFT_WAIT;
               end else if (right_ne) begin
                  cmd.push = 1'b1;
                  cmd.run  = right_run;
                  state_in = T_RIGHT_WAIT;
               end else begin
                  state_in = T_OUT;
               end
            end
         end
         T_LEFT_WAIT: begin
            if (stat.done) begin
               if (right_ne) begin
                  cmd.push = 1'b1;
                  cmd.run  = right_run;
                  state_in = T_RIGHT_WAIT;
               end else begin
                  state_in = T_OUT;
               end
            end
         end
         T_RIGHT_WAIT: begin
            if (stat.done) begin
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            // load the output register once the previous result is transferred
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_seat_in   = given_ff;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      seat_ff       <= seat_in;
      status_ff     <= status_in;
      given_ff      <= given_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seat_ff   <= rsp_seat_in;
      if (reset) begin
         state_ff     <= T_IDLE;
         next_ff      <= NW'(1);
         tail_ff      <= 1'b0;
         total_ff     <= lgms_pkg::TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall         = (state_ff != T_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_assigned_seat = rsp_seat_ff;

endmodule

// ===== hw/rtl/lgms_checker.sv =====
// Port-level checker for the seat allocator, bound to the top level.
// Depends on lgms_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "largest_gap_middle_seat_allocator_macros.svh"

module lgms_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lgms_pkg::STATUS_W-1:0] rsp_status,
   input logic [lgms_pkg::SEAT_W-1:0]   rsp_assigned_seat
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   `LGMS_ASSERT_SAME(a_status_code, rsp_valid, (rsp_status == lgms_pkg::STATUS_OK) || (rsp_status == lgms_pkg::STATUS_NO_SEAT) || (rsp_status == lgms_pkg::STATUS_BAD_PRESEAT), "result status is not a defined code")
   `LGMS_ASSERT_SAME(a_error_no_seat, rsp_valid && (rsp_status != lgms_pkg::STATUS_OK), rsp_assigned_seat == '0, "error result carries a seat")
   `LGMS_ASSERT_SAME(a_seat_range, rsp_valid, 32'(rsp_assigned_seat) <= lgms_pkg::MAX_SEATS, "assigned seat above the seat limit")
   `LGMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_assigned_seat), "stalled result changed")
   `LGMS_ASSERT_NEXT(a_busy_after_req, req_xfer, req_stall, "input not stalled after a transfer")

endmodule

bind largest_gap_middle_seat_allocator lgms_checker u_lgms_checker (.*);

// ===== tb/sv/largest_gap_middle_seat_allocator_tb.sv =====
// Self-checking testbench for the largest-gap middle-seat allocator.
// Keeps its own model of the free runs, checks every result in order.
// Depends on lgms_pkg and the largest_gap_middle_seat_allocator RTL.
`timescale 1ns / 1ps

module largest_gap_middle_seat_allocator_tb;

   localparam int SW  = lgms_pkg::SEAT_W;
   localparam int STW = lgms_pkg::STATUS_W;

   localparam int IDLE_PCT     = 26;
   localparam int QUIET_FROM   = 8000;
   localparam int QUIET_TO     = 13000;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic          mode;
      logic [SW-1:0] seat;
   } seat_req_type;

   typedef struct packed {
      logic [STW-1:0] status;
      logic [SW-1:0]  seat;
   } seat_grant_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   logic           req_mode = lgms_pkg::MODE_PRESEAT;
   logic [SW-1:0]  req_seat = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic [STW-1:0] rsp_status;
   logic [SW-1:0]  rsp_assigned_seat;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [SW-1:0]  csr_total_seats = lgms_pkg::TOTAL_RESET;

   seat_req_type   seat_requests[$];
   seat_grant_type predicted_grants[$];
   seat_req_type   req_item;
   seat_grant_type got_grant;
   seat_grant_type want_grant;
   int             mismatch_count = 0;
   int             cycle_count = 0;
   logic           hold_off = 1'b0;
   bit             hold_trigger = 1'b0;
   wire            quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   // model state: free runs, next seat after the last preseat, tail flag, register
   lgms_pkg::run_type free_runs[$];
   logic [SW-1:0]     next_free_start = SW'(1);
   logic              tail_added = 1'b0;
   logic [SW-1:0]     total_cfg = lgms_pkg::TOTAL_RESET;

   largest_gap_middle_seat_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_seat          (req_seat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_assigned_seat (rsp_assigned_seat),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_total_seats   (csr_total_seats)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // longer run wins, then the smaller start
   function automatic logic ranks_higher(lgms_pkg::run_type x, lgms_pkg::run_type y);
      if (x.len != y.len) begin
         return x.len > y.len;
      end
      return x.start < y.start;
   endfunction

   function automatic void add_run(logic [SW-1:0] len, logic [SW-1:0] start);
      lgms_pkg::run_type r;
      r.len = len;
      r.start = start;
      // drop when full, as the hardware does
      if (free_runs.size() < lgms_pkg::HEAP_ENTRIES) begin
         free_runs.push_back(r);
      end
   endfunction

   function automatic lgms_pkg::run_type take_best_run();
      int                best = 0;
      lgms_pkg::run_type r;
      for (int i = 1; i < free_runs.size(); i++) begin
         if (ranks_higher(free_runs[i], free_runs[best])) begin
            best = i;
         end
      end
      r = free_runs[best];
      free_runs.delete(best);
      return r;
   endfunction

   function automatic seat_grant_type grant_for(logic mode, logic [SW-1:0] seat);
      logic [SW:0]       limit;
      logic [SW:0]       last;
      logic [SW:0]       mid;
      lgms_pkg::run_type r;
      seat_grant_type    g;
      limit = (total_cfg > lgms_pkg::MAX_SEATS) ? (SW+1)'(lgms_pkg::MAX_SEATS)
                                                : {1'b0, total_cfg};
      g.status = lgms_pkg::STATUS_OK;
      g.seat = '0;
      if (mode == lgms_pkg::MODE_PRESEAT) begin
         if (tail_added || seat == 0 || seat > limit || seat < next_free_start) begin
            g.status = lgms_pkg::STATUS_BAD_PRESEAT;
         end else begin
            if (seat > next_free_start) begin
               add_run(seat - next_free_start, next_free_start);
            end
            next_free_start = seat + 1'b1;
         end
      end else begin
         if (!tail_added) begin
            tail_added = 1'b1;
            if (limit + (SW+1)'(1) > {1'b0, next_free_start}) begin
               add_run(SW'(limit + (SW+1)'(1) - {1'b0, next_free_start}), next_free_start);
            end
         end
         if (free_runs.size() == 0) begin
            g.status = lgms_pkg::STATUS_NO_SEAT;
         end else begin
            r = take_best_run();
            last = {1'b0, r.start} + {1'b0, r.len} - (SW+1)'(1);
            mid = ({1'b0, r.start} + last) >> 1;
            if (mid > {1'b0, r.start}) begin
               add_run(mid[SW-1:0] - r.start, r.start);
            end
            if (last > mid) begin
               add_run(SW'(last - mid), SW'(mid + (SW+1)'(1)));
            end
            g.seat = mid[SW-1:0];
         end
      end
      return g;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   // request driver: predict on each transfer, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_grants.push_back(grant_for(req_mode, req_seat));
         end
         if (!req_valid || !req_stall) begin
            if (seat_requests.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_item = seat_requests.pop_front();
               req_valid <= 1'b1;
               req_mode <= req_item.mode;
               req_seat <= req_item.seat;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_grant.status = rsp_status;
            got_grant.seat = rsp_assigned_seat;
            if (predicted_grants.size() == 0) begin
               report_mismatch($sformatf("unexpected result: status %0d seat %0d",
                                         got_grant.status, got_grant.seat));
            end else begin
               want_grant = predicted_grants.pop_front();
               if (got_grant.status !== want_grant.status ||
                   got_grant.seat !== want_grant.seat) begin
                  report_mismatch($sformatf(
                     "mismatch: status exp %0d got %0d, seat exp %0d got %0d",
                     want_grant.status, got_grant.status, want_grant.seat, got_grant.seat));
               end
            end
         end
         rsp_stall <= hold_off || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // long receiver hold-off so the block backs up onto its input
   initial begin
      wait (hold_trigger);
      repeat (30) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic queue_req(input logic mode, input logic [SW-1:0] seat);
      seat_req_type r;
      r.mode = mode;
      r.seat = seat;
      seat_requests.push_back(r);
   endtask

   task automatic write_total(input logic [SW-1:0] value);
      csr_valid <= 1'b1;
      csr_total_seats <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      total_cfg = value;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (seat_requests.size() != 0 || req_valid || predicted_grants.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_allocates(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 88) begin
            queue_req(lgms_pkg::MODE_ALLOCATE, SW'($urandom_range(0, 8191)));
         end else begin
            queue_req(lgms_pkg::MODE_PRESEAT, SW'($urandom_range(0, 8191)));
         end
      end
   endtask

   initial begin
      int pos;
      int budget;
      int gap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero seats: every preseat is rejected
      write_total('0);
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(1));
      queue_req(lgms_pkg::MODE_PRESEAT, '0);
      wait_idle();

      // register above range acts as the maximum
      write_total('1);
      queue_req(lgms_pkg::MODE_PRESEAT, '1);
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(lgms_pkg::MAX_SEATS + 1));
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(2));
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(2));
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(1));
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(3));
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(4));
      wait_idle();

      // ascending preseats with random gaps, mixed with rejected ones
      write_total(SW'(lgms_pkg::MAX_SEATS));
      pos = 5;
      budget = $urandom_range(500, 600);
      while (budget > 0) begin
         if ($urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 2))
               0: begin
                  queue_req(lgms_pkg::MODE_PRESEAT, '0);
               end
               1: begin
                  queue_req(lgms_pkg::MODE_PRESEAT,
                            SW'($urandom_range(lgms_pkg::MAX_SEATS + 1, 8191)));
               end
               default: begin
                  queue_req(lgms_pkg::MODE_PRESEAT, SW'($urandom_range(1, pos - 1)));
               end
            endcase
         end else begin
            gap = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(4, 60);
            if (gap > budget) begin
               gap = budget;
            end
            queue_req(lgms_pkg::MODE_PRESEAT, SW'(pos + gap));
            pos += gap + 1;
            budget -= gap;
         end
      end
      wait_idle();

      // lower the total to at most the last preseat: no trailing run
      write_total(SW'($urandom_range(1, pos - 1)));
      queue_req(lgms_pkg::MODE_ALLOCATE, '0);
      queue_req(lgms_pkg::MODE_PRESEAT, SW'(pos + 3));
      queue_req(lgms_pkg::MODE_ALLOCATE, '1);
      queue_req(lgms_pkg::MODE_ALLOCATE, SW'(lgms_pkg::MAX_SEATS));
      queue_random_allocates(300);
      hold_trigger = 1'b1;
      wait_idle();

      // register writes after the first allocate have no effect
      write_total(SW'(1));
      queue_random_allocates(250);
      wait_idle();

      write_total('1);
      queue_random_allocates(250);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
